FILE: hw/rtl/rail_voltage_scale_average_macros.svh
// Assertion macros for the rail monitor RTL.
`ifndef RAIL_VOLTAGE_SCALE_AVERAGE_MACROS_SVH
`define RAIL_VOLTAGE_SCALE_AVERAGE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RVSA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rvsa: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define RVSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rvsa: next-cycle check failed");

`endif

FILE: hw/rtl/rvsa_pkg.sv
`default_nettype none

package rvsa_pkg;

   localparam int NUM_STAGES = 6;
   localparam int NUM_LANES  = 3;

   localparam int LANE_POS5  = 0;
   localparam int LANE_POS12 = 1;
   localparam int LANE_NEG5  = 2;

   localparam int GAIN_W      = 20;
   localparam int OFFSET_W    = 16;
   localparam int VOLT_W      = 15;
   localparam int POS_W       = 14;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 20;
   localparam int ROUND_SHIFT = 16;

   localparam int VOLT_MIN = -16384;
   localparam int VOLT_MAX = 16383;

   localparam logic [GAIN_W-1:0]          GAIN_POS5_RESET   = 20'd105600;
   localparam logic [GAIN_W-1:0]          GAIN_POS12_RESET  = 20'd252212;
   localparam logic [GAIN_W-1:0]          GAIN_NEG5_RESET   = 20'd254569;
   localparam logic signed [OFFSET_W-1:0] OFFSET_NEG5_RESET = -16'sd12611;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_POS5   = 2'd0,
      CSR_GAIN_POS12  = 2'd1,
      CSR_GAIN_NEG5   = 2'd2,
      CSR_OFFSET_NEG5 = 2'd3
   } rvsa_csr_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] en;
      logic                  accept;
      logic                  ram_we;
      logic                  sum_we;
      logic                  old_valid;
   } rvsa_ctrl_type;

endpackage

`default_nettype wire

FILE: hw/rtl/rvsa_if.sv
`default_nettype none

interface rvsa_req_if #(parameter int ADC_BITS = 12);
   logic                valid;
   logic                ready;
   logic [ADC_BITS-1:0] raw_pos5;
   logic [ADC_BITS-1:0] raw_pos12;
   logic [ADC_BITS-1:0] raw_neg5;

   modport source (output valid, output raw_pos5, output raw_pos12, output raw_neg5,
                   input ready);
   modport sink (input valid, input raw_pos5, input raw_pos12, input raw_neg5,
                 output ready);
endinterface

interface rvsa_rsp_if;
   import rvsa_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [POS_W-1:0]         volt_pos5;
   logic [POS_W-1:0]         volt_pos12;
   logic signed [VOLT_W-1:0] volt_neg5;
   logic [POS_W-1:0]         mean_pos5;
   logic [POS_W-1:0]         mean_pos12;
   logic signed [VOLT_W-1:0] mean_neg5;

   modport source (output valid, output volt_pos5, output volt_pos12, output volt_neg5,
                   output mean_pos5, output mean_pos12, output mean_neg5, input ready);
   modport sink (input valid, input volt_pos5, input volt_pos12, input volt_neg5,
                 input mean_pos5, input mean_pos12, input mean_neg5, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/rail_voltage_scale_average.sv
// An accepted transaction passes the product, ring, sum, magnitude, reciprocal and output
// registers to rsp_if. Throughput: one transaction per cycle unless a low rsp_if.ready
// stalls the six-stage pipeline; each ring memory has one write and one read port.
// Reset (synchronous, active high) empties the pipeline, zeroes position and sums,
// clears the ring entry valid bits and loads the default calibration at once.
`default_nettype none
`include "rail_voltage_scale_average_macros.svh"

module rail_voltage_scale_average #(
   parameter int WINDOW   = 50,
   parameter int ADC_BITS = 12
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   rvsa_req_if.sink                                 req_if,
   rvsa_rsp_if.source                               rsp_if,
   input  wire logic                                csr_we,
   input  wire logic [rvsa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [rvsa_pkg::CSR_DATA_W-1:0]     csr_data
);

   import rvsa_pkg::*;

   localparam int AW = $clog2(WINDOW);

   logic [GAIN_W-1:0]          gain_ff [NUM_LANES];
   logic [GAIN_W-1:0]          gain_in [NUM_LANES];
   logic signed [OFFSET_W-1:0] offset_ff;
   logic signed [OFFSET_W-1:0] offset_in;

   rvsa_ctrl_type              ctrl;
   logic [AW-1:0]              rd_addr;
   logic [AW-1:0]              wr_addr;

   logic [ADC_BITS-1:0]        lane_raw    [NUM_LANES];
   logic signed [OFFSET_W-1:0] lane_offset [NUM_LANES];
   logic signed [VOLT_W-1:0]   lane_volt   [NUM_LANES];
   logic signed [VOLT_W-1:0]   lane_mean   [NUM_LANES];

   logic signed [VOLT_W-1:0]   out_volt_ff [NUM_LANES];
   logic signed [VOLT_W-1:0]   out_mean_ff [NUM_LANES];

   always_comb begin
      gain_in   = gain_ff;
      offset_in = offset_ff;
      if (csr_we) begin
         case (rvsa_csr_type'(csr_index))
            CSR_GAIN_POS5: begin
               gain_in[LANE_POS5] = csr_data[GAIN_W-1:0];
            end
            CSR_GAIN_POS12: begin
               gain_in[LANE_POS12] = csr_data[GAIN_W-1:0];
            end
            CSR_GAIN_NEG5: begin
               gain_in[LANE_NEG5] = csr_data[GAIN_W-1:0];
            end
            CSR_OFFSET_NEG5: begin
               offset_in = csr_data[OFFSET_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff[LANE_POS5]  <= GAIN_POS5_RESET;
         gain_ff[LANE_POS12] <= GAIN_POS12_RESET;
         gain_ff[LANE_NEG5]  <= GAIN_NEG5_RESET;
         offset_ff           <= OFFSET_NEG5_RESET;
      end else begin
         gain_ff   <= gain_in;
         offset_ff <= offset_in;
      end
   end

   rvsa_ctrl #(
      .WINDOW (WINDOW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .rsp_ready (rsp_if.ready),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .ctrl      (ctrl),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr)
   );

   // The positive rails carry no offset.
   always_comb begin
      lane_raw[LANE_POS5]     = req_if.raw_pos5;
      lane_raw[LANE_POS12]    = req_if.raw_pos12;
      lane_raw[LANE_NEG5]     = req_if.raw_neg5;
      lane_offset[LANE_POS5]  = '0;
      lane_offset[LANE_POS12] = '0;
      lane_offset[LANE_NEG5]  = offset_ff;
   end

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      rvsa_lane #(
         .WINDOW   (WINDOW),
         .ADC_BITS (ADC_BITS)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .rd_addr (rd_addr),
         .wr_addr (wr_addr),
         .raw     (lane_raw[i]),
         .gain    (gain_ff[i]),
         .offset  (lane_offset[i]),
         .volt    (lane_volt[i]),
         .mean    (lane_mean[i])
      );
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[NUM_STAGES-1]) begin
         out_volt_ff <= lane_volt;
         out_mean_ff <= lane_mean;
      end
   end

   assign rsp_if.volt_pos5  = out_volt_ff[LANE_POS5][POS_W-1:0];
   assign rsp_if.volt_pos12 = out_volt_ff[LANE_POS12][POS_W-1:0];
   assign rsp_if.volt_neg5  = out_volt_ff[LANE_NEG5];
   assign rsp_if.mean_pos5  = out_mean_ff[LANE_POS5][POS_W-1:0];
   assign rsp_if.mean_pos12 = out_mean_ff[LANE_POS12][POS_W-1:0];
   assign rsp_if.mean_neg5  = out_mean_ff[LANE_NEG5];

   `RVSA_ASSERT_IMPL(a_pos_rails_nonneg, clock, reset, rsp_if.valid,
      !out_volt_ff[LANE_POS5][VOLT_W-1] && !out_mean_ff[LANE_POS5][VOLT_W-1] &&
      !out_volt_ff[LANE_POS12][VOLT_W-1] && !out_mean_ff[LANE_POS12][VOLT_W-1])
   `RVSA_ASSERT_NEXT(a_gain_pos5_write, clock, reset,
      csr_we && (csr_index == CSR_GAIN_POS5),
      gain_ff[LANE_POS5] == $past(csr_data[GAIN_W-1:0]))
   `RVSA_ASSERT_NEXT(a_offset_write, clock, reset,
      csr_we && (csr_index == CSR_OFFSET_NEG5),
      offset_ff == $past(csr_data[OFFSET_W-1:0]))

endmodule

`default_nettype wire

FILE: hw/rtl/rvsa_ram.sv
`default_nettype none

module rvsa_ram #(
   parameter int WIDTH = 15,
   parameter int DEPTH = 50
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/rvsa_ctrl.sv
`default_nettype none

module rvsa_ctrl #(
   parameter int WINDOW = 50
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      rsp_ready,
   output logic                           req_ready,
   output logic                           rsp_valid,
   output rvsa_pkg::rvsa_ctrl_type        ctrl,
   output logic [$clog2(WINDOW)-1:0]      rd_addr,
   output logic [$clog2(WINDOW)-1:0]      wr_addr
);

   import rvsa_pkg::*;

   localparam int AW = $clog2(WINDOW);

   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES:0]   ready;
   logic [AW-1:0]         pos_ff;
   logic [AW-1:0]         pos_in;
   logic [AW-1:0]         a_pos_ff;
   logic [WINDOW-1:0]     entry_vld_ff;
   logic [WINDOW-1:0]     entry_vld_in;
   logic                  old_valid_ff;
   logic                  accept;

   // A stage takes new data whenever it is empty or its successor moves.
   always_comb begin
      ready[NUM_STAGES] = rsp_ready;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         ready[k] = !vld_ff[k] || ready[k+1];
      end
   end

   always_comb begin
      vld_in = vld_ff;
      for (int k = 0; k < NUM_STAGES; k++) begin
         if (ready[k]) begin
            vld_in[k] = (k == 0) ? req_valid : vld_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   assign accept = req_valid && ready[0];

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         pos_in = (pos_ff == AW'(WINDOW - 1)) ? '0 : pos_ff + 1'b1;
      end
   end

   always_comb begin
      ctrl.en        = ready[NUM_STAGES-1:0];
      ctrl.accept    = accept;
      ctrl.ram_we    = ready[1] && vld_ff[0];
      ctrl.sum_we    = ready[2] && vld_ff[1];
      ctrl.old_valid = old_valid_ff;
   end

   // Ring entries never written since reset read as zero.
   always_comb begin
      entry_vld_in = entry_vld_ff;
      if (ctrl.ram_we) begin
         entry_vld_in[a_pos_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         pos_ff       <= '0;
         entry_vld_ff <= '0;
      end else begin
         vld_ff       <= vld_in;
         pos_ff       <= pos_in;
         entry_vld_ff <= entry_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_pos_ff     <= pos_ff;
         old_valid_ff <= entry_vld_ff[pos_ff];
      end
   end

   assign req_ready = ready[0];
   assign rsp_valid = vld_ff[NUM_STAGES-1];
   assign rd_addr   = pos_ff;
   assign wr_addr   = a_pos_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/rvsa_lane.sv
`default_nettype none

module rvsa_lane #(
   parameter int WINDOW   = 50,
   parameter int ADC_BITS = 12
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire rvsa_pkg::rvsa_ctrl_type               ctrl,
   input  wire logic [$clog2(WINDOW)-1:0]             rd_addr,
   input  wire logic [$clog2(WINDOW)-1:0]             wr_addr,
   input  wire logic [ADC_BITS-1:0]                   raw,
   input  wire logic [rvsa_pkg::GAIN_W-1:0]           gain,
   input  wire logic signed [rvsa_pkg::OFFSET_W-1:0]  offset,
   output logic signed [rvsa_pkg::VOLT_W-1:0]         volt,
   output logic signed [rvsa_pkg::VOLT_W-1:0]         mean
);

   import rvsa_pkg::*;

   localparam int AW      = $clog2(WINDOW);
   localparam int PROD_W  = ADC_BITS + GAIN_W;
   localparam int MV_W    = PROD_W + 1 - ROUND_SHIFT;
   localparam int SC_W    = ADC_BITS + 10;
   localparam int SUM_W   = AW + 16;
   localparam int MAG_W   = SUM_W - 1;
   localparam int SHIFT   = MAG_W + AW;
   localparam int RECIP_W = MAG_W + 2;
   localparam int QPROD_W = MAG_W + RECIP_W;

   localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (ROUND_SHIFT - 1);
   localparam logic signed [SC_W-1:0] SC_MIN = SC_W'(VOLT_MIN);
   localparam logic signed [SC_W-1:0] SC_MAX = SC_W'(VOLT_MAX);
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

   logic [PROD_W-1:0]        a_prod_ff;
   logic [PROD_W:0]          rounded;
   logic [MV_W-1:0]          mv;
   logic signed [SC_W-1:0]   sc_value;
   logic signed [VOLT_W-1:0] volt_in;
   logic [VOLT_W-1:0]        ring_rd;

   logic signed [VOLT_W-1:0] b_volt_ff;
   logic signed [VOLT_W-1:0] b_old_ff;

   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [SUM_W-1:0]  sum_in;
   logic signed [VOLT_W-1:0] c_volt_ff;
   logic signed [SUM_W-1:0]  c_sum_ff;

   logic [SUM_W-1:0]         mag_full;
   logic signed [VOLT_W-1:0] d_volt_ff;
   logic [MAG_W-1:0]         d_mag_ff;
   logic                     d_neg_ff;

   logic signed [VOLT_W-1:0] e_volt_ff;
   logic [QPROD_W-1:0]       e_prod_ff;
   logic                     e_neg_ff;
   logic [VOLT_W-1:0]        quot;

   // Round the Q16 product half up, add the offset, then saturate.
   always_comb begin
      rounded  = {1'b0, a_prod_ff} + ROUND_HALF;
      mv       = rounded[PROD_W:ROUND_SHIFT];
      sc_value = $signed({{(SC_W - MV_W){1'b0}}, mv})
               + $signed({{(SC_W - OFFSET_W){offset[OFFSET_W-1]}}, offset});
      if (sc_value < SC_MIN) begin
         volt_in = VOLT_W'(VOLT_MIN);
      end else if (sc_value > SC_MAX) begin
         volt_in = VOLT_W'(VOLT_MAX);
      end else begin
         volt_in = sc_value[VOLT_W-1:0];
      end
   end

   rvsa_ram #(
      .WIDTH (VOLT_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .we      (ctrl.ram_we),
      .wr_addr (wr_addr),
      .wr_data (volt_in),
      .rd_en   (ctrl.accept),
      .rd_addr (rd_addr),
      .rd_data (ring_rd)
   );

   always_comb begin
      sum_in = sum_ff
             - $signed({{(SUM_W - VOLT_W){b_old_ff[VOLT_W-1]}}, b_old_ff})
             + $signed({{(SUM_W - VOLT_W){b_volt_ff[VOLT_W-1]}}, b_volt_ff});
      mag_full = c_sum_ff[SUM_W-1] ? SUM_W'(-c_sum_ff) : c_sum_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (ctrl.sum_we) begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[0]) begin
         a_prod_ff <= PROD_W'(raw) * PROD_W'(gain);
      end
      if (ctrl.en[1]) begin
         b_volt_ff <= volt_in;
         b_old_ff  <= ctrl.old_valid ? ring_rd : '0;
      end
      if (ctrl.en[2]) begin
         c_volt_ff <= b_volt_ff;
         c_sum_ff  <= sum_in;
      end
      if (ctrl.en[3]) begin
         d_volt_ff <= c_volt_ff;
         d_mag_ff  <= mag_full[MAG_W-1:0];
         d_neg_ff  <= c_sum_ff[SUM_W-1];
      end
      if (ctrl.en[4]) begin
         e_volt_ff <= d_volt_ff;
         e_prod_ff <= QPROD_W'(d_mag_ff) * QPROD_W'(RECIP);
         e_neg_ff  <= d_neg_ff;
      end
   end

   // The reciprocal is rounded up far enough that the quotient is exact.
   assign quot = e_prod_ff[SHIFT +: VOLT_W];
   assign mean = e_neg_ff ? $signed(-quot) : $signed(quot);
   assign volt = e_volt_ff;

endmodule

`default_nettype wire
